/* hdl/cih_pkg.sv */
// cih_pkg: shared constants, codes and controller/datapath interface types
// for the class id histogram table.
// No dependencies.
package cih_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int COUNT_BITS  = 32;
   localparam int ADDR_W      = $clog2(MAX_ENTRIES);
   localparam int USED_W      = $clog2(MAX_ENTRIES + 1);

   // port widths
   localparam int FUNC_W    = 2;
   localparam int ID_W      = 8;
   localparam int STATUS_W  = 3;
   localparam int SLOT_W    = 6;
   localparam int COUNT_W   = 32;
   localparam int ENTRIES_W = 7;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [FUNC_W-1:0] {
      FN_COUNT = 2'd0,
      FN_ZERO  = 2'd1,
      FN_CLEAR = 2'd2,
      FN_RSVD  = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT     = 3'd0,
      ST_NEW     = 3'd1,
      ST_RANGE   = 3'd2,
      ST_FULL    = 3'd3,
      ST_ZEROED  = 3'd4,
      ST_CLEARED = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_ZERO
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       idx_clear;
      logic       idx_inc;
      logic       rd_en;
      logic       wr_zero;
      logic       wr_new;
      logic       wr_hit;
      logic       clr_used;
      logic       rsp_en;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic used_zero;
      logic full;
      logic idx_end;
      logic zero_last;
      logic hit;
      logic range_err;
   } stat_type;

endpackage

/* hdl/cih_ctrl.sv */
// cih_ctrl: request sequencer for the class id histogram table.
// Drives cih_datapath through cmd_type commands; uses cih_pkg.
module cih_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_func,
   input  cih_pkg::stat_type stat,
   output cih_pkg::cmd_type  cmd,
   output logic              busy
);
   import cih_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;
   func_type  func;

   assign accept = start && (state_ff == S_IDLE);
   assign func   = func_type'(req_func);
   assign busy   = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (func)
                  FN_COUNT: begin
                     if (!stat.range_err) begin
                        state_in = S_SEARCH;
                     end
                  end
                  FN_ZERO: begin
                     if (!stat.used_zero) begin
                        state_in = S_ZERO;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SEARCH: begin
            if (stat.hit || stat.idx_end) begin
               state_in = S_IDLE;
            end
         end
         S_ZERO: begin
            if (stat.zero_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd            = '0;
      cmd.rsp_status = ST_HIT;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (func)
                  FN_COUNT: begin
                     cmd.load_req  = 1'b1;
                     cmd.idx_clear = 1'b1;
                     if (stat.range_err) begin
                        cmd.rsp_en     = 1'b1;
                        cmd.rsp_status = ST_RANGE;
                     end
                  end
                  FN_ZERO: begin
                     cmd.idx_clear = 1'b1;
                     if (stat.used_zero) begin
                        cmd.rsp_en     = 1'b1;
                        cmd.rsp_status = ST_ZEROED;
                     end
                  end
                  FN_CLEAR: begin
                     cmd.clr_used   = 1'b1;
                     cmd.rsp_en     = 1'b1;
                     cmd.rsp_status = ST_CLEARED;
                  end
                  default: cmd = '0;
               endcase
            end
         end
         S_SEARCH: begin
            if (stat.hit) begin
               cmd.wr_hit     = 1'b1;
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = ST_HIT;
            end else if (stat.idx_end) begin
               // every used slot compared without a match
               cmd.rsp_en = 1'b1;
               if (stat.full) begin
                  cmd.rsp_status = ST_FULL;
               end else begin
                  cmd.wr_new     = 1'b1;
                  cmd.rsp_status = ST_NEW;
               end
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.idx_inc = 1'b1;
            end
         end
         S_ZERO: begin
            cmd.wr_zero = 1'b1;
            if (stat.zero_last) begin
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = ST_ZEROED;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

endmodule

/* hdl/cih_datapath.sv */
// cih_datapath: id and count memories, slot index, fill count and result
// registers for the class id histogram table. Uses cih_pkg.
module cih_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [cih_pkg::ID_W-1:0]       req_class_id,
   input  cih_pkg::cmd_type               cmd,
   output cih_pkg::stat_type              stat,
   output logic                           rsp_strobe,
   output logic [cih_pkg::STATUS_W-1:0]   rsp_status,
   output logic [cih_pkg::SLOT_W-1:0]     rsp_slot,
   output logic [cih_pkg::COUNT_W-1:0]    rsp_count_now,
   output logic [cih_pkg::ENTRIES_W-1:0]  rsp_entries_in_use
);
   import cih_pkg::*;

   logic [ID_W-1:0]       id_mem_ff  [MAX_ENTRIES];
   logic [COUNT_BITS-1:0] cnt_mem_ff [MAX_ENTRIES];

   logic [ID_W-1:0]       req_id_ff;
   logic [ID_W-1:0]       rd_id_ff;
   logic [COUNT_BITS-1:0] rd_cnt_ff;
   logic [ADDR_W-1:0]     rd_slot_ff;

   logic                  rd_valid_ff, rd_valid_in;
   logic [USED_W-1:0]     used_ff, used_in;
   logic [USED_W-1:0]     idx_ff, idx_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;

   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic [ENTRIES_W-1:0]  rsp_entries_ff;

   logic [ADDR_W-1:0]     idx_addr;
   logic [ADDR_W-1:0]     used_addr;
   logic [USED_W-1:0]     idx_plus;
   logic [COUNT_BITS-1:0] sat_cnt;
   logic                  cnt_we;
   logic [ADDR_W-1:0]     cnt_waddr;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic [ADDR_W-1:0]     slot_sel;
   logic [COUNT_BITS-1:0] count_sel;
   logic [USED_W-1:0]     used_after;

   assign idx_addr  = idx_ff[ADDR_W-1:0];
   assign used_addr = used_ff[ADDR_W-1:0];
   assign idx_plus  = idx_ff + USED_W'(1);
   assign sat_cnt   = (rd_cnt_ff == COUNT_MAX) ? rd_cnt_ff : rd_cnt_ff + COUNT_BITS'(1);

   // status to the controller
   assign stat.used_zero = (used_ff == '0);
   assign stat.full      = (used_ff == USED_W'(MAX_ENTRIES));
   assign stat.idx_end   = (idx_ff == used_ff);
   assign stat.zero_last = (idx_plus == used_ff);
   assign stat.hit       = rd_valid_ff && (rd_id_ff == req_id_ff);
   assign stat.range_err = ({1'b0, req_class_id} > (ID_W + 1)'(MAX_ENTRIES));

   // single count write port shared by hit, append and zero sweep
   always_comb begin
      cnt_we    = cmd.wr_hit || cmd.wr_new || cmd.wr_zero;
      cnt_waddr = idx_addr;
      cnt_wdata = '0;
      if (cmd.wr_hit) begin
         cnt_waddr = rd_slot_ff;
         cnt_wdata = sat_cnt;
      end else if (cmd.wr_new) begin
         cnt_waddr = used_addr;
         cnt_wdata = COUNT_BITS'(1);
      end
   end

   always_comb begin
      used_in = used_ff;
      if (cmd.clr_used) begin
         used_in = '0;
      end else if (cmd.wr_new) begin
         used_in = used_ff + USED_W'(1);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_plus;
      end
   end

   assign rd_valid_in   = cmd.rd_en;
   assign rsp_strobe_in = cmd.rsp_en;

   always_comb begin
      slot_sel  = '0;
      count_sel = '0;
      if (cmd.wr_hit) begin
         slot_sel  = rd_slot_ff;
         count_sel = sat_cnt;
      end else if (cmd.wr_new) begin
         slot_sel  = used_addr;
         count_sel = COUNT_BITS'(1);
      end
   end

   assign used_after = used_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= '0;
         idx_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         used_ff       <= used_in;
         idx_ff        <= idx_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_id_ff <= req_class_id;
      end
      if (cmd.rd_en) begin
         rd_id_ff   <= id_mem_ff[idx_addr];
         rd_cnt_ff  <= cnt_mem_ff[idx_addr];
         rd_slot_ff <= idx_addr;
      end
      if (cmd.wr_new) begin
         id_mem_ff[used_addr] <= req_id_ff;
      end
      if (cnt_we) begin
         cnt_mem_ff[cnt_waddr] <= cnt_wdata;
      end
      if (cmd.rsp_en) begin
         rsp_status_ff  <= cmd.rsp_status;
         rsp_slot_ff    <= SLOT_W'(slot_sel);
         rsp_count_ff   <= COUNT_W'(count_sel);
         rsp_entries_ff <= ENTRIES_W'(used_after);
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_count_now      = rsp_count_ff;
   assign rsp_entries_in_use = rsp_entries_ff;

endmodule

/* hdl/class_id_histogram_table.sv */
// class_id_histogram_table: top level, controller plus datapath.
// Depends on cih_pkg, cih_ctrl and cih_datapath.
//
//   channel   ports                                    transfer
//   request   start, busy, req_func, req_class_id      start high while busy low
//   result    rsp_strobe, rsp_status, rsp_slot,        one cycle with rsp_strobe high
//             rsp_count_now, rsp_entries_in_use
//
// count: the search reads one slot per cycle, then compares and writes back
// zero: sweeps every used slot; zero on an empty table, clear, out of range
//   id and unused func codes: busy stays low; unused func codes give no result
// the result strobe comes the cycle after the last cycle of the request
// synchronous reset empties the table; memory contents need no reset
// results cannot be held off; the next request may start while one is shown
module class_id_histogram_table (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [cih_pkg::FUNC_W-1:0]     req_func,
   input  logic [cih_pkg::ID_W-1:0]       req_class_id,
   output logic                           rsp_strobe,
   output logic [cih_pkg::STATUS_W-1:0]   rsp_status,
   output logic [cih_pkg::SLOT_W-1:0]     rsp_slot,
   output logic [cih_pkg::COUNT_W-1:0]    rsp_count_now,
   output logic [cih_pkg::ENTRIES_W-1:0]  rsp_entries_in_use
);
   import cih_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   cih_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   cih_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_class_id       (req_class_id),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_slot           (rsp_slot),
      .rsp_count_now      (rsp_count_now),
      .rsp_entries_in_use (rsp_entries_in_use)
   );

`ifndef NO_ASSERTIONS
   // every result is issued on the way back to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // a clear answers in the next cycle with an empty table
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FN_CLEAR) |=>
         (rsp_strobe && rsp_status == ST_CLEARED && rsp_entries_in_use == '0))
      else $error("clear result wrong");

   // a counted entry never reports zero
   a_hit_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_HIT || rsp_status == ST_NEW)) |->
         (rsp_count_now != '0))
      else $error("counted entry with zero count");

   // fill count never passes the table size
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_entries_in_use <= ENTRIES_W'(MAX_ENTRIES)))
      else $error("entries in use beyond table size");
`endif

endmodule

/* bench/class_id_histogram_table_tb.sv */
// class_id_histogram_table_tb: self-checking bench for the class id histogram table.
// Drives count, zero, clear and unused-code requests at random gaps; checks every result
// against a table model or fixed rows. Depends on cih_pkg and class_id_histogram_table.
`timescale 1ns / 1ps

module class_id_histogram_table_tb;
   import cih_pkg::*;

   localparam int RANDOM_ITEMS = 2000;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 2 * MAX_ENTRIES + 16;
   localparam int MAX_REPORTS  = 60;

   typedef struct packed {
      status_type             status;
      logic [SLOT_W-1:0]      slot;
      logic [COUNT_W-1:0]     count;
      logic [ENTRIES_W-1:0]   entries;
   } hist_rsp_type;

   typedef struct packed {
      func_type               fn;
      logic [ID_W-1:0]        id;
      logic                   typed;
      hist_rsp_type           rsp;
   } dir_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [FUNC_W-1:0]      req_func = FN_COUNT;
   logic [ID_W-1:0]        req_class_id = '0;
   logic                   rsp_strobe;
   logic [STATUS_W-1:0]    rsp_status;
   logic [SLOT_W-1:0]      rsp_slot;
   logic [COUNT_W-1:0]     rsp_count_now;
   logic [ENTRIES_W-1:0]   rsp_entries_in_use;

   // predictor copy of the table
   logic [ID_W-1:0]        tab_id [MAX_ENTRIES];
   logic [COUNT_BITS-1:0]  tab_count [MAX_ENTRIES];
   int                     tab_used = 0;

   hist_rsp_type           pending_rsp [$];
   dir_row_type            directed_rows [$];
   int                     err_count = 0;
   int                     cycle_count = 0;
   int                     items_done = 0;

   class_id_histogram_table u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_class_id       (req_class_id),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_slot           (rsp_slot),
      .rsp_count_now      (rsp_count_now),
      .rsp_entries_in_use (rsp_entries_in_use)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_rsp.size());
         $display("class_id_histogram_table_tb: done, errors");
         $finish;
      end
   end

   task automatic report(input string msg);
      if (err_count < MAX_REPORTS)
         $display("%0t: %s", $realtime, msg);
      err_count++;
   endtask

   // updates the table copy and returns the result the request should give
   function automatic hist_rsp_type update_histogram(input func_type fn,
                                                     input logic [ID_W-1:0] id,
                                                     output bit has_rsp);
      hist_rsp_type r;
      int           hit_slot;
      r = '{status: ST_HIT, slot: '0, count: '0, entries: '0};
      hit_slot = -1;
      has_rsp = 1'b1;
      case (fn)
         FN_ZERO: begin
            for (int i = 0; i < tab_used; i++)
               tab_count[i] = '0;
            r.status = ST_ZEROED;
         end
         FN_CLEAR: begin
            tab_used = 0;
            r.status = ST_CLEARED;
         end
         FN_COUNT: begin
            if (id > MAX_ENTRIES) begin
               r.status = ST_RANGE;
            end else begin
               for (int i = 0; i < tab_used; i++)
                  if (hit_slot < 0 && tab_id[i] == id)
                     hit_slot = i;
               if (hit_slot >= 0) begin
                  // saturate at the top of the count range
                  if (tab_count[hit_slot] != COUNT_MAX)
                     tab_count[hit_slot] = tab_count[hit_slot] + 1'b1;
                  r.status = ST_HIT;
                  r.slot   = SLOT_W'(hit_slot);
                  r.count  = COUNT_W'(tab_count[hit_slot]);
               end else if (tab_used >= MAX_ENTRIES) begin
                  r.status = ST_FULL;
               end else begin
                  tab_id[tab_used]    = id;
                  tab_count[tab_used] = 1;
                  r.status = ST_NEW;
                  r.slot   = SLOT_W'(tab_used);
                  r.count  = 1;
                  tab_used++;
               end
            end
         end
         default: has_rsp = 1'b0;
      endcase
      r.entries = ENTRIES_W'(tab_used);
      return r;
   endfunction

   // called at a falling edge; returns at a falling edge after the gap
   task automatic send_request(input func_type fn, input logic [ID_W-1:0] id, input int gap,
                               input bit typed, input hist_rsp_type typed_rsp);
      hist_rsp_type r;
      bit           has_rsp;
      start        <= 1'b1;
      req_func     <= fn;
      req_class_id <= id;
      do @(posedge clock); while (busy);
      r = update_histogram(fn, id, has_rsp);
      if (has_rsp)
         pending_rsp.push_back(typed ? typed_rsp : r);
      @(negedge clock);
      if (gap > 0) begin
         start        <= 1'b0;
         req_func     <= FUNC_W'($urandom);
         req_class_id <= ID_W'($urandom);
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic int pick_gap(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic dir_row_type mk_row(input func_type fn, input logic [ID_W-1:0] id,
                                          input bit typed, input status_type st,
                                          input int slot, input int cnt, input int ent);
      dir_row_type d;
      d.fn    = fn;
      d.id    = id;
      d.typed = typed;
      d.rsp   = '{status: st, slot: SLOT_W'(slot), count: COUNT_W'(cnt),
                  entries: ENTRIES_W'(ent)};
      return d;
   endfunction

   task automatic count_random(input func_type fn, input logic [ID_W-1:0] id, input bit quiet);
      send_request(fn, id, pick_gap(quiet), 1'b0, '0);
      if (fn != FN_RSVD)
         items_done++;
   endtask

   // clear, then every legal id once in shuffled order: the last one finds the table full
   task automatic fill_table(input bit quiet);
      int order [MAX_ENTRIES + 1];
      int j;
      int tmp;
      for (int i = 0; i <= MAX_ENTRIES; i++)
         order[i] = i;
      for (int i = MAX_ENTRIES; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      count_random(FN_CLEAR, ID_W'($urandom), quiet);
      for (int i = 0; i <= MAX_ENTRIES; i++)
         count_random(FN_COUNT, ID_W'(order[i]), quiet);
      repeat ($urandom_range(4, 20)) begin
         if ($urandom_range(0, 9) == 0)
            count_random(FN_ZERO, ID_W'($urandom), quiet);
         else
            count_random(FN_COUNT, ID_W'($urandom_range(0, MAX_ENTRIES)), quiet);
      end
   endtask

   task automatic mixed_phase(input bit quiet);
      int n;
      int pool_hi;
      int r;
      n = $urandom_range(20, 80);
      pool_hi = $urandom_range(3, MAX_ENTRIES);
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 70)
            count_random(FN_COUNT, ID_W'($urandom_range(0, pool_hi)), quiet);
         else if (r < 78)
            count_random(FN_COUNT, ID_W'($urandom_range(MAX_ENTRIES + 1, 255)), quiet);
         else if (r < 84)
            count_random(FN_COUNT, ID_W'($urandom_range(0, 255)), quiet);
         else if (r < 90)
            count_random(FN_ZERO, ID_W'($urandom), quiet);
         else if (r < 93)
            count_random(FN_CLEAR, ID_W'($urandom), quiet);
         else
            count_random(FN_RSVD, ID_W'($urandom), quiet);
      end
   endtask

   always @(posedge clock) begin : check_rsp
      hist_rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            report($sformatf("unexpected result: status %0d slot %0d count %0d entries %0d",
                             rsp_status, rsp_slot, rsp_count_now, rsp_entries_in_use));
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status)
               report($sformatf("status: expected %0d got %0d", want.status, rsp_status));
            if (rsp_slot !== want.slot)
               report($sformatf("slot: expected %0d got %0d", want.slot, rsp_slot));
            if (rsp_count_now !== want.count)
               report($sformatf("count_now: expected %0d got %0d", want.count, rsp_count_now));
            if (rsp_entries_in_use !== want.entries)
               report($sformatf("entries_in_use: expected %0d got %0d",
                                want.entries, rsp_entries_in_use));
         end
      end
   end

   initial begin
      bit quiet;
      // directed rows: extremes of the id, ids just past the legal range,
      // the unused func code, zero on a non-empty and an empty table, and clear
      directed_rows.push_back(mk_row(FN_COUNT, 8'd0,   1, ST_NEW,     0, 1, 1));
      directed_rows.push_back(mk_row(FN_COUNT, 8'd64,  1, ST_NEW,     1, 1, 2));
      directed_rows.push_back(mk_row(FN_COUNT, 8'd0,   1, ST_HIT,     0, 2, 2));
      directed_rows.push_back(mk_row(FN_COUNT, 8'd65,  1, ST_RANGE,   0, 0, 2));
      directed_rows.push_back(mk_row(FN_COUNT, 8'd255, 1, ST_RANGE,   0, 0, 2));
      directed_rows.push_back(mk_row(FN_RSVD,  8'd0,   0, ST_HIT,     0, 0, 0));
      directed_rows.push_back(mk_row(FN_COUNT, 8'd170, 1, ST_RANGE,   0, 0, 2));
      directed_rows.push_back(mk_row(FN_COUNT, 8'd85,  1, ST_RANGE,   0, 0, 2));
      directed_rows.push_back(mk_row(FN_ZERO,  8'd255, 1, ST_ZEROED,  0, 0, 2));
      directed_rows.push_back(mk_row(FN_COUNT, 8'd64,  1, ST_HIT,     1, 1, 2));
      directed_rows.push_back(mk_row(FN_COUNT, 8'd0,   1, ST_HIT,     0, 1, 2));
      directed_rows.push_back(mk_row(FN_COUNT, 8'd33,  1, ST_NEW,     2, 1, 3));
      directed_rows.push_back(mk_row(FN_COUNT, 8'd33,  0, ST_HIT,     0, 0, 0));
      directed_rows.push_back(mk_row(FN_COUNT, 8'd64,  0, ST_HIT,     0, 0, 0));
      directed_rows.push_back(mk_row(FN_CLEAR, 8'd85,  1, ST_CLEARED, 0, 0, 0));
      directed_rows.push_back(mk_row(FN_ZERO,  8'd0,   1, ST_ZEROED,  0, 0, 0));
      directed_rows.push_back(mk_row(FN_COUNT, 8'd63,  1, ST_NEW,     0, 1, 1));
      directed_rows.push_back(mk_row(FN_COUNT, 8'd63,  0, ST_HIT,     0, 0, 0));
      directed_rows.push_back(mk_row(FN_RSVD,  8'd255, 0, ST_HIT,     0, 0, 0));
      directed_rows.push_back(mk_row(FN_COUNT, 8'd1,   0, ST_HIT,     0, 0, 0));
      directed_rows.push_back(mk_row(FN_ZERO,  8'd170, 0, ST_HIT,     0, 0, 0));
      directed_rows.push_back(mk_row(FN_COUNT, 8'd1,   0, ST_HIT,     0, 0, 0));
      directed_rows.push_back(mk_row(FN_CLEAR, 8'd0,   1, ST_CLEARED, 0, 0, 0));

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // first half back to back, second half with gaps
      foreach (directed_rows[i])
         send_request(directed_rows[i].fn, directed_rows[i].id,
                      (i < 12) ? 0 : $urandom_range(0, 3),
                      directed_rows[i].typed, directed_rows[i].rsp);

      fill_table(1'b0);
      while (items_done < RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 2)
            fill_table(quiet);
         else
            mixed_phase(quiet);
      end

      start <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (err_count == 0 && pending_rsp.size() == 0)
         $display("class_id_histogram_table_tb: done, clean");
      else
         $display("class_id_histogram_table_tb: done, errors");
      $finish;
   end

endmodule
